/* rtl/amg_pkg.sv */
// ----------------------------------------------------------------------------
// amg_pkg - shared types for the adjacency matrix graph store
// Operation codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package amg_pkg;

  localparam int unsigned VTX_W  = 6;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned IN_DW  = 16;
  localparam int unsigned OUT_DW = 8;
  localparam int unsigned OUT_UW = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUCC = 2'd1,
    OP_PRED = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

/* rtl/adjacency_matrix_graph_store_top.sv */
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_top - directed graph kept as a bit matrix
//
// Input stream: in_tuser carries the operation (add edge, successor query,
// predecessor query), in_tdata the two vertices. An add returns nothing.
// A query returns one transfer per neighbor in ascending order, with tlast
// on the final one; a query with no neighbors returns one empty transfer,
// and a query on a vertex at or above vertex_count returns one transfer
// with the bad-vertex flag set.
// The matrix is one memory row per vertex. A single scan counter walks the
// vertices one per cycle: a successor query first loads the source row into
// a register in the load state, a predecessor query reads one row per cycle
// and picks the column bit. The vertex count in use is vertex_count limited
// to MAX_VERTICES. in_tready is high only in the idle state, so no new item
// is taken while a query still scans or an add still writes. Each hit is
// held back until the next one so that tlast can be set on the final one. A
// stalled receiver pauses the scan; the output register lets the next item
// be taken while the last result waits. After reset a clearing pass writes
// MAX_VERTICES zero rows, one per cycle, before the first item.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_top #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [amg_pkg::IN_DW-1:0]    in_tdata,   // vertex_a [5:0], vertex_b [11:6]
  input  logic [amg_pkg::OP_W-1:0]     in_tuser,   // op [1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [amg_pkg::OUT_DW-1:0]   out_tdata,  // neighbour [5:0]
  output logic [amg_pkg::OUT_UW-1:0]   out_tuser,  // found [0], bad_vertex [1]
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [amg_pkg::CNT_W-1:0]    cfg_wr_data
);
  import amg_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = (VW + 1 > CNT_W) ? VW + 1 : CNT_W;

  // adjacency memory: row i, bit j set means edge (i, j)
  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];

  state_t                  state_r, state_nxt;
  logic [VW-1:0]           j_r, j_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [VW-1:0]           pend_j_r, pend_j_nxt;
  logic                    bad_r, bad_nxt;
  logic                    prev_r, prev_nxt;
  logic [VW-1:0]           a_r, a_nxt;
  logic [VW-1:0]           b_r, b_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic [MAX_VERTICES-1:0] rd_data_r;
  logic [CNT_W-1:0]        vc_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]        out_nb_r, out_nb_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_bad_r, out_bad_nxt;

  logic                    we;
  logic [VW-1:0]           wa;
  logic [MAX_VERTICES-1:0] wd;
  logic [VW-1:0]           ra;

  logic [CW-1:0]           eff_n;
  logic [VTX_W-1:0]        in_a, in_b;
  op_t                     in_op;
  logic                    in_xfer, a_ok, b_ok, out_free, cur_bit, at_end;

  assign in_a    = in_tdata[VTX_W-1:0];
  assign in_b    = in_tdata[2*VTX_W-1:VTX_W];
  assign in_op   = op_t'(in_tuser);
  assign in_xfer = in_tvalid && in_tready;
  assign eff_n   = (CW'(vc_r) < CW'(MAX_VERTICES)) ? CW'(vc_r) : CW'(MAX_VERTICES);
  assign a_ok    = CW'(in_a) < eff_n;
  assign b_ok    = CW'(in_b) < eff_n;
  assign out_free = !out_valid_r || out_tready;
  assign cur_bit = prev_r ? rd_data_r[a_r] : row_r[j_r];
  assign at_end  = CW'(j_r) == eff_n - CW'(1);

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_nb_r);
  assign out_tuser  = {out_bad_r, out_found_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    j_nxt          = j_r;
    pend_valid_nxt = pend_valid_r;
    pend_j_nxt     = pend_j_r;
    bad_nxt        = bad_r;
    prev_nxt       = prev_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_nb_nxt     = out_nb_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    out_bad_nxt    = out_bad_r;
    we             = 1'b0;
    wa             = j_r;
    wd             = '0;
    ra             = j_r;

    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (j_r == VW'(MAX_VERTICES - 1)) begin
          state_nxt = ST_IDLE;
          j_nxt     = '0;
        end else begin
          j_nxt = j_r + VW'(1);
        end
      end
      ST_IDLE: begin
        ra = (in_op == OP_PRED) ? '0 : VW'(in_a);
        a_nxt          = VW'(in_a);
        b_nxt          = VW'(in_b);
        prev_nxt       = in_op == OP_PRED;
        j_nxt          = '0;
        pend_valid_nxt = 1'b0;
        if (in_xfer) begin
          case (in_op)
            OP_ADD: begin
              if (a_ok && b_ok) state_nxt = ST_ADD_WR;
            end
            OP_SUCC, OP_PRED: begin
              bad_nxt = !a_ok;
              if (!a_ok)               state_nxt = ST_FLUSH;
              else if (in_op == OP_PRED) state_nxt = ST_SCAN;
              else                     state_nxt = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        we        = 1'b1;
        wa        = a_r;
        wd        = rd_data_r | (MAX_VERTICES'(1) << b_r);
        state_nxt = ST_IDLE;
      end
      ST_LOAD: begin
        row_nxt   = rd_data_r;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // hold the scan when a hit must push the pending one out and cannot
        if (!(cur_bit && pend_valid_r && !out_free)) begin
          if (cur_bit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nb_nxt    = VTX_W'(pend_j_r);
              out_found_nxt = 1'b1;
              out_last_nxt  = 1'b0;
              out_bad_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_j_nxt     = j_r;
          end
          ra = j_r + VW'(1);
          if (at_end) begin
            state_nxt = ST_FLUSH;
          end else begin
            j_nxt = j_r + VW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nb_nxt     = pend_valid_r ? VTX_W'(pend_j_r) : '0;
          out_found_nxt  = pend_valid_r;
          out_last_nxt   = 1'b1;
          out_bad_nxt    = bad_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      j_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      vc_r         <= CNT_W'(64);
    end else begin
      state_r      <= state_nxt;
      j_r          <= j_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        vc_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_j_r    <= pend_j_nxt;
    bad_r       <= bad_nxt;
    prev_r      <= prev_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    row_r       <= row_nxt;
    out_nb_r    <= out_nb_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("pending hit left over after a query");

  a_bad_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_op == OP_SUCC || in_op == OP_PRED) && !a_ok |=> state_r == ST_FLUSH)
    else $error("bad queried vertex did not go straight to flush");

  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && !out_found_r)
    else $error("bad-vertex result must be a single empty last transfer");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> CW'(j_r) < eff_n)
    else $error("scan index beyond vertex count");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && pend_valid_r |-> pend_j_r < j_r)
    else $error("pending hit not below scan index");

endmodule
